/* hdl/shgb_pkg.sv */
// Package with the transaction types, state codes and hash constants of the grid build.
`timescale 1ns / 1ps
`default_nettype none
package shgb_pkg;

   localparam int unsigned KindWidth   = 2;
   localparam int unsigned PosWidth    = 24;
   localparam int unsigned IndexWidth  = 13;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned ValueWidth  = 11;
   localparam int unsigned CsrWidth    = 16;

   localparam logic [31:0] PrimeX = 32'd73856093;
   localparam logic [31:0] PrimeY = 32'd19349663;
   localparam logic [31:0] PrimeZ = 32'd83492791;

   localparam logic [KindWidth-1:0] KindLoad  = 2'd0;
   localparam logic [KindWidth-1:0] KindStart = 2'd1;
   localparam logic [KindWidth-1:0] KindEntry = 2'd2;

   localparam logic [StatusWidth-1:0] StatusOk   = 2'd0;
   localparam logic [StatusWidth-1:0] StatusFull = 2'd1;
   localparam logic [StatusWidth-1:0] StatusBad  = 2'd2;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic signed [PosWidth-1:0] pos_x;
      logic signed [PosWidth-1:0] pos_y;
      logic signed [PosWidth-1:0] pos_z;
      logic                  last;
      logic [IndexWidth-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ValueWidth-1:0]  value;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_PRIME,
      ST_HASH_WRITE,
      ST_CLEAR,
      ST_HIST_RD,
      ST_HIST_WAIT,
      ST_HIST_WR,
      ST_PREFIX_RD,
      ST_PREFIX_WAIT,
      ST_PREFIX_WR,
      ST_SENTINEL,
      ST_SCAT_RD,
      ST_SCAT_WAIT,
      ST_SCAT_WR,
      ST_READ_WAIT,
      ST_READ_OUT,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request
      logic mul_coord;   // position times inverse cell size
      logic mul_prime;   // coordinate times prime
      logic hash_write;  // store hash, count the load
      logic ptr_clear;   // zero the walk pointer
      logic ptr_inc;     // advance the walk pointer
      logic clear_wr;    // write a zero count
      logic hist_rd;     // read hash of particle at pointer
      logic hist_cnt_rd; // read count of that cell
      logic hist_wr;     // write count plus one
      logic pre_rd;      // read count at pointer
      logic pre_wr;      // write start and cursor, accumulate
      logic sent_wr;     // write sentinel total
      logic scat_wr;     // write entry, bump cursor
      logic build_done;  // mark the table built
      logic read_issue;  // issue a read transaction lookup
      logic read_take;   // take the read data
      logic respond;     // drive the result strobe
   } cmd_type;

   typedef struct packed {
      logic       is_load;
      logic       is_read;
      logic       last;
      logic       full;
      logic       ptr_at_table_end;
      logic       ptr_at_count_end;
   } sts_type;

endpackage
`default_nettype wire

/* hdl/shgb_ram.sv */
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module shgb_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // One access per cycle; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

/* hdl/shgb_ctrl.sv */
// Controller state machine for loads, build passes and reads.
`timescale 1ns / 1ps
`default_nettype none
module shgb_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire shgb_pkg::sts_type  sts,
   output      shgb_pkg::cmd_type  cmd,
   output      logic               busy
);
   import shgb_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_HASH_MUL;
         end
         ST_HASH_MUL: begin
            if (!sts.is_load) state_in = sts.is_read ? ST_READ_WAIT : ST_RESPOND;
            else state_in = ST_HASH_PRIME;
         end
         ST_HASH_PRIME: state_in = ST_HASH_WRITE;
         ST_HASH_WRITE: state_in = sts.last ? ST_CLEAR : ST_RESPOND;
         ST_CLEAR: begin
            if (sts.ptr_at_table_end) state_in = ST_HIST_RD;
         end
         ST_HIST_RD: state_in = sts.ptr_at_count_end ? ST_PREFIX_RD : ST_HIST_WAIT;
         ST_HIST_WAIT: state_in = ST_HIST_WR;
         ST_HIST_WR: state_in = ST_HIST_RD;
         ST_PREFIX_RD: state_in = ST_PREFIX_WAIT;
         ST_PREFIX_WAIT: state_in = ST_PREFIX_WR;
         ST_PREFIX_WR: state_in = sts.ptr_at_table_end ? ST_SENTINEL : ST_PREFIX_RD;
         ST_SENTINEL: state_in = ST_SCAT_RD;
         ST_SCAT_RD: state_in = sts.ptr_at_count_end ? ST_RESPOND : ST_SCAT_WAIT;
         ST_SCAT_WAIT: state_in = ST_SCAT_WR;
         ST_SCAT_WR: state_in = ST_SCAT_RD;
         ST_READ_WAIT: state_in = ST_READ_OUT;
         ST_READ_OUT: state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: cmd.capture = start;
         ST_HASH_MUL: begin
            cmd.mul_coord = 1'b1;
            cmd.read_issue = sts.is_read;
         end
         ST_HASH_PRIME: cmd.mul_prime = 1'b1;
         ST_HASH_WRITE: begin
            cmd.hash_write = 1'b1;
            cmd.ptr_clear = 1'b1;
         end
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.ptr_inc = !sts.ptr_at_table_end;
            cmd.ptr_clear = sts.ptr_at_table_end;
         end
         ST_HIST_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.ptr_clear = sts.ptr_at_count_end;
         end
         ST_HIST_WAIT: cmd.hist_cnt_rd = 1'b1;
         ST_HIST_WR: begin
            cmd.hist_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         ST_PREFIX_RD: cmd.pre_rd = 1'b1;
         ST_PREFIX_WAIT: cmd.pre_rd = 1'b1;
         ST_PREFIX_WR: begin
            cmd.pre_wr = 1'b1;
            cmd.ptr_inc = !sts.ptr_at_table_end;
            cmd.ptr_clear = sts.ptr_at_table_end;
         end
         ST_SENTINEL: cmd.sent_wr = 1'b1;
         ST_SCAT_RD: begin
            cmd.hist_rd = 1'b1;
            cmd.build_done = sts.ptr_at_count_end;
         end
         ST_SCAT_WAIT: cmd.hist_cnt_rd = 1'b1;
         ST_SCAT_WR: begin
            cmd.scat_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
         end
         ST_READ_WAIT: cmd.read_issue = 1'b1;
         ST_READ_OUT: cmd.read_take = 1'b1;
         ST_RESPOND: cmd.respond = 1'b1;
         default: cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

/* hdl/shgb_datapath.sv */
// Datapath: hash arithmetic, table memories, walk pointer and result register.
`timescale 1ns / 1ps
`default_nettype none
module shgb_datapath #(
   parameter int unsigned TableSize    = 4096,
   parameter int unsigned MaxParticles = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire shgb_pkg::cmd_type       cmd,
   input  wire shgb_pkg::req_type       req,
   input  wire logic [shgb_pkg::CsrWidth-1:0] inv_size,
   output      shgb_pkg::sts_type       sts,
   output      shgb_pkg::rsp_type       rsp
);
   import shgb_pkg::*;

   localparam int unsigned HashBits = $clog2(TableSize);
   localparam int unsigned PartBits = $clog2(MaxParticles);
   localparam int unsigned CntBits  = $clog2(MaxParticles + 1);
   localparam int unsigned StartAw  = $clog2(TableSize + 1);
   localparam int unsigned PtrBits  = (HashBits > PartBits ? HashBits : PartBits) + 1;
   localparam int unsigned ProdBits = PosWidth + CsrWidth + 1;

   req_type req_ff;
   logic [CntBits-1:0]  loaded_ff, loaded_in;
   logic                built_ff, built_in;
   logic [PtrBits-1:0]  ptr_ff, ptr_in;
   logic [CntBits-1:0]  sum_ff, sum_in;
   logic [CntBits-1:0]  sent_ff, sent_in;
   logic [31:0]         coord_ff [3];
   logic [31:0]         term_ff [3];
   logic [HashBits-1:0] cell_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                read_ok_ff, read_ok_in;
   logic                read_kind_ff, read_kind_in;

   // Memory ports.
   logic                hash_we;
   logic [PartBits-1:0] hash_addr;
   logic [HashBits-1:0] hash_rd;
   logic                cnt_we;
   logic [HashBits-1:0] cnt_addr;
   logic [CntBits-1:0]  cnt_wd, cnt_rd;
   logic                start_we;
   logic [StartAw-1:0]  start_addr;
   logic [CntBits-1:0]  start_wd, start_rd;
   logic                ent_we;
   logic [PartBits-1:0] ent_addr;
   logic [PartBits-1:0] ent_rd;
   logic                full;

   // Floor of position times inverse cell size, per axis.
   function automatic logic [31:0] floor_coord(input logic signed [PosWidth-1:0] p,
                                                input logic [CsrWidth-1:0] s);
      logic signed [ProdBits-1:0] prod;
      logic signed [ProdBits-1:0] sh;
      begin
         prod = ProdBits'(p) * $signed({1'b0, s});
         sh = prod >>> 20;
         floor_coord = 32'(sh);
      end
   endfunction

   // Request capture and hash pipeline.
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req;
      if (cmd.mul_coord) begin
         coord_ff[0] <= floor_coord(req_ff.pos_x, inv_size);
         coord_ff[1] <= floor_coord(req_ff.pos_y, inv_size);
         coord_ff[2] <= floor_coord(req_ff.pos_z, inv_size);
      end
      if (cmd.mul_prime) begin
         term_ff[0] <= coord_ff[0] * PrimeX;
         term_ff[1] <= coord_ff[1] * PrimeY;
         term_ff[2] <= coord_ff[2] * PrimeZ;
      end
      if (cmd.hist_cnt_rd) cell_ff <= hash_rd;
   end

   logic [HashBits-1:0] hash_new;
   assign hash_new = HashBits'(term_ff[0] ^ term_ff[1] ^ term_ff[2]);

   // Memories.
   assign full = (loaded_ff == CntBits'(MaxParticles));
   assign hash_we = cmd.hash_write && !full;
   assign hash_addr = cmd.hash_write ? PartBits'(loaded_ff) : PartBits'(ptr_ff);

   always_comb begin
      cnt_we = 1'b0;
      cnt_addr = HashBits'(ptr_ff);
      cnt_wd = '0;
      if (cmd.clear_wr) begin
         cnt_we = 1'b1;
      end else if (cmd.hist_cnt_rd) begin
         cnt_addr = hash_rd;
      end else if (cmd.hist_wr) begin
         cnt_addr = cell_ff;
         cnt_we = 1'b1;
         cnt_wd = cnt_rd + 1'b1;
      end else if (cmd.pre_wr) begin
         cnt_we = 1'b1;
         cnt_wd = sum_ff;
      end else if (cmd.scat_wr) begin
         cnt_addr = cell_ff;
         cnt_we = 1'b1;
         cnt_wd = cnt_rd + 1'b1;
      end
   end

   always_comb begin
      start_we = cmd.pre_wr || cmd.sent_wr;
      start_addr = cmd.sent_wr ? StartAw'(TableSize) : StartAw'(ptr_ff);
      start_wd = cmd.sent_wr ? sum_ff : sum_ff;
      if (cmd.read_issue) start_addr = StartAw'(req_ff.read_index);
      ent_we = cmd.scat_wr && (cnt_rd < CntBits'(MaxParticles));
      ent_addr = cmd.scat_wr ? PartBits'(cnt_rd) : PartBits'(req_ff.read_index);
   end

   shgb_ram #(.Width(HashBits), .Depth(MaxParticles)) u_hash (
      .clock(clock), .wr_en(hash_we), .addr(hash_addr), .wr_data(hash_new),
      .rd_data(hash_rd));
   shgb_ram #(.Width(CntBits), .Depth(TableSize)) u_cursor (
      .clock(clock), .wr_en(cnt_we), .addr(cnt_addr), .wr_data(cnt_wd),
      .rd_data(cnt_rd));
   shgb_ram #(.Width(CntBits), .Depth(TableSize + 1)) u_start (
      .clock(clock), .wr_en(start_we), .addr(start_addr), .wr_data(start_wd),
      .rd_data(start_rd));
   shgb_ram #(.Width(PartBits), .Depth(MaxParticles)) u_entry (
      .clock(clock), .wr_en(ent_we), .addr(ent_addr), .wr_data(PartBits'(ptr_ff)),
      .rd_data(ent_rd));

   // Control registers and walk state.
   always_comb begin
      loaded_in = loaded_ff;
      built_in = built_ff;
      ptr_in = ptr_ff;
      sum_in = sum_ff;
      sent_in = sent_ff;
      if (cmd.hash_write) begin
         built_in = 1'b0;
         if (!full) loaded_in = loaded_ff + 1'b1;
         sum_in = '0;
      end
      if (cmd.ptr_clear) ptr_in = '0;
      else if (cmd.ptr_inc) ptr_in = ptr_ff + 1'b1;
      if (cmd.pre_wr) sum_in = sum_ff + cnt_rd;
      if (cmd.sent_wr) sent_in = sum_ff;
      if (cmd.build_done) begin
         built_in = 1'b1;
         loaded_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         built_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         loaded_ff <= loaded_in;
         built_ff <= built_in;
         ptr_ff <= ptr_in;
      end
      sum_ff <= sum_in;
      sent_ff <= sent_in;
      rsp_ff <= rsp_in;
      read_ok_ff <= read_ok_in;
      read_kind_ff <= read_kind_in;
   end

   // Result formation.
   always_comb begin
      rsp_in = rsp_ff;
      read_ok_in = read_ok_ff;
      read_kind_in = read_kind_ff;
      if (cmd.mul_coord) begin
         rsp_in.status = StatusBad;
         rsp_in.value = '0;
         read_kind_in = (req_ff.kind == KindStart);
         if (req_ff.kind == KindStart)
            read_ok_in = built_ff && (req_ff.read_index <= IndexWidth'(TableSize));
         else
            read_ok_in = built_ff && (32'(req_ff.read_index) < 32'(sent_ff))
                         && (32'(req_ff.read_index) < 32'(MaxParticles));
      end
      if (cmd.hash_write) begin
         rsp_in.status = full ? StatusFull : StatusOk;
         rsp_in.value = full ? '0 : ValueWidth'(loaded_ff);
      end
      if (cmd.read_take && read_ok_ff) begin
         rsp_in.status = StatusOk;
         rsp_in.value = read_kind_ff ? ValueWidth'(start_rd) : ValueWidth'(ent_rd);
      end
   end

   assign rsp = rsp_ff;
   assign sts.is_load = (req_ff.kind == KindLoad);
   assign sts.is_read = (req_ff.kind == KindStart) || (req_ff.kind == KindEntry);
   assign sts.last = req_ff.last;
   assign sts.full = full;
   assign sts.ptr_at_table_end = (ptr_ff == PtrBits'(TableSize - 1));
   assign sts.ptr_at_count_end = (32'(ptr_ff) >= 32'(loaded_ff));
endmodule
`default_nettype wire

/* hdl/spatial_hash_grid_build.sv */
// Top level of the spatial hash grid build block.
//
//  channel  | handshake              | payload
//  req      | start, busy            | req_data (kind, pos_x/y/z, last, read_index)
//  rsp      | rsp_valid (one cycle)  | rsp_data (status, value)
//  csr      | csr_valid, csr_ready   | csr_data (inverse_cell_size)
//
// A load runs the coordinate and prime multiplies and the hash write, a read the
// coordinate multiply, read wait and read out; a bad kind only the multiply. A last
// load adds clear, histogram, prefix and scatter passes over single-port memories.
// Reset is synchronous; memories are not cleared and are written before use.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none
module spatial_hash_grid_build #(
   parameter int unsigned TABLE_SIZE    = 4096,
   parameter int unsigned MAX_PARTICLES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire shgb_pkg::req_type             req_data,
   output      logic                          rsp_valid,
   output      shgb_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [shgb_pkg::CsrWidth-1:0] csr_data
);
   import shgb_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [CsrWidth-1:0] inv_ff;

   // Configuration register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) inv_ff <= CsrWidth'(12800);
      else if (csr_valid) inv_ff <= csr_data;
   end

   shgb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy));

   shgb_datapath #(.TableSize(TABLE_SIZE), .MaxParticles(MAX_PARTICLES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data), .inv_size(inv_ff),
      .sts(sts), .rsp(rsp_data));

   assign rsp_valid = cmd.respond;
endmodule
`default_nettype wire

/* hdl/shgb_checker.sv */
// Port-level checker for the grid build block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module shgb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire shgb_pkg::rsp_type rsp_data
);
   import shgb_pkg::*;

   // An accepted transaction makes the block busy.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("not busy after accept");
   // A result ends the transaction.
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   // Results only appear while busy.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result while idle");
   // A result strobe is a single cycle.
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result");
   // Status codes stay in range.
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
endmodule

bind spatial_hash_grid_build shgb_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data));
`default_nettype wire
